@@ rtl/ima_pkg.sv @@
// Shared types and widths for the 3x3 matrix inverse pipeline.
// Used by every module under rtl; depends on nothing else.
package ima_pkg;

    localparam int ELEMENT_WIDTH = 32;
    localparam int FRAC_BITS     = 24;

    localparam int EW   = ELEMENT_WIDTH;
    localparam int CW   = 2 * EW + 1;
    localparam int DW   = 3 * EW + 3;
    localparam int NW   = CW + 2 * FRAC_BITS;
    localparam int SW   = (NW > DW + EW) ? NW : DW + EW;
    localparam int NST  = EW + 8;

    typedef logic signed [EW-1:0]   elem_t;
    typedef logic signed [2*EW-1:0] prod_t;
    typedef logic signed [CW-1:0]   cof_t;
    typedef logic signed [DW-1:0]   det_t;

    typedef struct packed {
        logic [EW-1:0] value;
        logic          ovf;
        logic          zero;
    } res_t;

endpackage

@@ rtl/invert_3x3_matrix.sv @@
// Top level of the 3x3 matrix inverse: cofactor lanes, determinant merge,
// nine division lanes. Depends on ima_pkg and the ima_* lane modules.
//
// Channel | Direction | Beat contents
// s_      | in        | tdata: a00..a22, 32 bits each
// m_      | out       | tdata: b00..b22, 32 bits each; tuser: singular, overflow
//
// One matrix is accepted every cycle while no result waits on m_tready.
// The division lanes resolve one quotient bit per stage. The whole pipeline
// advances together and holds while a result waits on m_tready. Reset empties
// the pipeline; data registers are not reset.
module invert_3x3_matrix import ima_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [9*EW-1:0]   s_tdata,   // a00, a01, a02, a10, a11, a12, a20, a21, a22
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [9*EW-1:0]   m_tdata,   // b00, b01, b02, b10, b11, b12, b20, b21, b22
    output logic [1:0]        m_tuser    // singular, overflow
);

    logic            adv;
    logic [NST-1:0]  v_reg;
    elem_t           a      [3][3];
    cof_t            cof    [3][3];
    cof_t            cofd_reg [3][3][3];
    elem_t           a0_reg [2][3];
    elem_t           a0d    [3];
    cof_t            c0     [3];
    det_t            det;
    res_t            res    [3][3];
    logic            ovf_any;

    assign adv      = !v_reg[NST-1] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = v_reg[NST-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= {v_reg[NST-2:0], s_tvalid};
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_row
        for (genvar j = 0; j < 3; j++) begin : g_col
            assign a[i][j] = s_tdata[(i*3+j)*EW +: EW];
            ima_cof_lane u_cof (
                .aclk (aclk),
                .en   (adv),
                .p    (a[(i+1)%3][(j+1)%3]),
                .q    (a[(i+2)%3][(j+2)%3]),
                .r    (a[(i+1)%3][(j+2)%3]),
                .s    (a[(i+2)%3][(j+1)%3]),
                .cof  (cof[i][j])
            );
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int j = 0; j < 3; j++) begin
                a0_reg[0][j] <= a[0][j];
                a0_reg[1][j] <= a0_reg[0][j];
            end
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    cofd_reg[0][i][j] <= cof[i][j];
                    cofd_reg[1][i][j] <= cofd_reg[0][i][j];
                    cofd_reg[2][i][j] <= cofd_reg[1][i][j];
                end
            end
        end
    end

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            a0d[j] = a0_reg[1][j];
            c0[j]  = cof[0][j];
        end
    end

    ima_det u_det (
        .aclk (aclk),
        .en   (adv),
        .a0   (a0d),
        .c0   (c0),
        .det  (det)
    );

    for (genvar i = 0; i < 3; i++) begin : g_orow
        for (genvar j = 0; j < 3; j++) begin : g_ocol
            ima_div_lane u_div (
                .aclk (aclk),
                .en   (adv),
                .c    (cofd_reg[2][j][i]),
                .d    (det),
                .res  (res[i][j])
            );
            assign m_tdata[(i*3+j)*EW +: EW] = res[i][j].value;
        end
    end

    always_comb begin
        ovf_any = 1'b0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                ovf_any = ovf_any | res[i][j].ovf;
            end
        end
    end

    assign m_tuser = {ovf_any, res[0][0].zero};

`ifndef ASSERT_OFF
    a_singular_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> (m_tuser[1] == 1'b0) && (m_tdata == '0))
        else $error("singular result carries nonzero data or overflow");

    a_stall_only_on_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input held off without a waiting result");

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_hold_keeps_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tuser) && $stable(m_tdata))
        else $error("held result changed");
`endif

endmodule

@@ rtl/ima_cof_lane.sv @@
// One cofactor lane: two products and their difference over two stages.
// Depends on ima_pkg.
module ima_cof_lane import ima_pkg::*; (
    input  logic  aclk,
    input  logic  en,
    input  elem_t p,
    input  elem_t q,
    input  elem_t r,
    input  elem_t s,
    output cof_t  cof
);

    prod_t m1_reg;
    prod_t m2_reg;
    cof_t  cof_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            m1_reg  <= p * q;
            m2_reg  <= r * s;
            cof_reg <= cof_t'(m1_reg) - cof_t'(m2_reg);
        end
    end

    assign cof = cof_reg;

endmodule

@@ rtl/ima_det.sv @@
// Determinant merge: expands along row zero with split partial products.
// Depends on ima_pkg.
module ima_det import ima_pkg::*; (
    input  logic  aclk,
    input  logic  en,
    input  elem_t a0 [3],
    input  cof_t  c0 [3],
    output det_t  det
);

    logic signed [2*EW:0] plo_reg [3];
    logic signed [2*EW:0] phi_reg [3];
    det_t                 t_reg   [3];
    det_t                 det_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < 3; j++) begin
                plo_reg[j] <= a0[j] * $signed({1'b0, c0[j][EW-1:0]});
                phi_reg[j] <= a0[j] * $signed(c0[j][CW-1:EW]);
                t_reg[j]   <= (det_t'(phi_reg[j]) <<< EW) + det_t'(plo_reg[j]);
            end
            det_reg <= t_reg[0] + t_reg[1] + t_reg[2];
        end
    end

    assign det = det_reg;

endmodule

@@ rtl/ima_div_lane.sv @@
// Division lane: one adjugate entry over the determinant, one quotient bit
// per stage, then saturation. Depends on ima_pkg.
module ima_div_lane import ima_pkg::*; (
    input  logic aclk,
    input  logic en,
    input  cof_t c,
    input  det_t d,
    output res_t res
);

    logic             neg0_reg;
    logic             zero0_reg;
    logic [CW-1:0]    cm0_reg;
    logic [DW-1:0]    dm0_reg;

    logic [NW-1:0]    rem_reg  [EW+1];
    logic [EW-1:0]    q_reg    [EW+1];
    logic [DW-1:0]    dm_reg   [EW+1];
    logic             neg_reg  [EW+1];
    logic             zero_reg [EW+1];
    logic             high_reg [EW+1];
    res_t             res_reg;

    logic [NW-1:0]    num;
    logic [EW-1:0]    qf;
    logic             ovf_c;
    logic [EW-1:0]    val_c;

    assign num = NW'(cm0_reg) << (2 * FRAC_BITS);

    always_ff @(posedge aclk) begin
        if (en) begin
            neg0_reg    <= c[CW-1] ^ d[DW-1];
            zero0_reg   <= (d == '0);
            cm0_reg     <= c[CW-1] ? CW'(-c) : CW'(c);
            dm0_reg     <= d[DW-1] ? DW'(-d) : DW'(d);
            rem_reg[0]  <= num;
            q_reg[0]    <= '0;
            dm_reg[0]   <= dm0_reg;
            neg_reg[0]  <= neg0_reg;
            zero_reg[0] <= zero0_reg;
            high_reg[0] <= SW'(num) >= (SW'(dm0_reg) << EW);
        end
    end

    for (genvar j = 0; j < EW; j++) begin : g_step
        localparam int K = EW - 1 - j;
        logic [SW-1:0] dsh;
        logic          ge;
        logic [EW-1:0] qn;

        always_comb begin
            dsh   = SW'(dm_reg[j]) << K;
            ge    = SW'(rem_reg[j]) >= dsh;
            qn    = q_reg[j];
            qn[K] = ge;
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j+1]  <= ge ? NW'(SW'(rem_reg[j]) - dsh) : rem_reg[j];
                q_reg[j+1]    <= qn;
                dm_reg[j+1]   <= dm_reg[j];
                neg_reg[j+1]  <= neg_reg[j];
                zero_reg[j+1] <= zero_reg[j];
                high_reg[j+1] <= high_reg[j];
            end
        end
    end

    always_comb begin
        qf = q_reg[EW];
        if (zero_reg[EW]) begin
            ovf_c = 1'b0;
            val_c = '0;
        end else if (!neg_reg[EW]) begin
            ovf_c = high_reg[EW] || qf[EW-1];
            val_c = ovf_c ? {1'b0, {(EW-1){1'b1}}} : qf;
        end else begin
            ovf_c = high_reg[EW] || (qf[EW-1] && (qf[EW-2:0] != '0));
            val_c = ovf_c ? {1'b1, {(EW-1){1'b0}}} : EW'(-qf);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg.value <= val_c;
            res_reg.ovf   <= ovf_c;
            res_reg.zero  <= zero_reg[EW];
        end
    end

    assign res = res_reg;

endmodule

@@ bench/invert_3x3_matrix_test.sv @@
// Self-checking bench for invert_3x3_matrix: random and directed 3x3 matrices,
// an adjugate-over-determinant predictor and a scoreboard. Depends on ima_pkg.
`timescale 1ns / 1ps

module invert_3x3_matrix_test;
    import ima_pkg::*;

    typedef logic signed [255:0] wide_t;
    typedef struct {
        logic [9*EW-1:0] entries;
        logic            singular;
        logic            overflow;
    } inverse_t;

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [9*EW-1:0]   s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    logic [9*EW-1:0]   m_tdata;
    logic [1:0]        m_tuser;

    logic              in_beat;
    logic              out_beat;
    logic [9*EW-1:0]   in_snap;
    logic [9*EW-1:0]   out_snap;
    logic [1:0]        user_snap;
    logic              calm;
    int                errors;
    int                quiet_cycles;

    invert_3x3_matrix u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        errors++;
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    endtask

    class inverse_board;
        inverse_t pending[$];

        function automatic inverse_t invert(logic [9*EW-1:0] m);
            wide_t   a[3][3];
            wide_t   cof[3][3];
            wide_t   det;
            wide_t   q;
            wide_t   top;
            wide_t   bottom;
            inverse_t r;
            top    = (wide_t'(1) <<< (EW - 1)) - 1;
            bottom = -(wide_t'(1) <<< (EW - 1));
            for (int i = 0; i < 9; i++) begin
                a[i / 3][i % 3] = wide_t'(elem_t'(m[i*EW +: EW]));
            end
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    cof[i][j] = a[(i+1)%3][(j+1)%3] * a[(i+2)%3][(j+2)%3]
                              - a[(i+1)%3][(j+2)%3] * a[(i+2)%3][(j+1)%3];
                end
            end
            det = a[0][0] * cof[0][0] + a[0][1] * cof[0][1] + a[0][2] * cof[0][2];
            r.entries  = '0;
            r.singular = (det == 0);
            r.overflow = 1'b0;
            if (det != 0) begin
                for (int i = 0; i < 3; i++) begin
                    for (int j = 0; j < 3; j++) begin
                        q = (cof[j][i] * (wide_t'(1) <<< (2 * FRAC_BITS))) / det;
                        if (q > top) begin
                            q = top;
                            r.overflow = 1'b1;
                        end else if (q < bottom) begin
                            q = bottom;
                            r.overflow = 1'b1;
                        end
                        r.entries[(i*3+j)*EW +: EW] = q[EW-1:0];
                    end
                end
            end
            return r;
        endfunction

        function void note(logic [9*EW-1:0] m);
            pending.push_back(invert(m));
        endfunction

        task check(logic [9*EW-1:0] got, logic [1:0] flags);
            inverse_t want;
            if (pending.size() == 0) begin
                report("unexpected beat", 64'(got[EW-1:0]), 64'd0);
                return;
            end
            want = pending.pop_front();
            for (int k = 0; k < 9; k++) begin
                if (got[k*EW +: EW] !== want.entries[k*EW +: EW]) begin
                    report($sformatf("b%0d%0d", k / 3, k % 3), 64'(got[k*EW +: EW]),
                           64'(want.entries[k*EW +: EW]));
                end
            end
            if (flags[0] !== want.singular) report("singular", 64'(flags[0]), 64'(want.singular));
            if (flags[1] !== want.overflow) report("overflow", 64'(flags[1]), 64'(want.overflow));
        endtask
    endclass

    inverse_board board = new();

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        in_beat   = s_tvalid && s_tready;
        out_beat  = m_tvalid && m_tready;
        in_snap   = s_tdata;
        out_snap  = m_tdata;
        user_snap = m_tuser;
    end

    always @(posedge aclk) begin
        if (aresetn && in_beat) board.note(in_snap);
        if (aresetn && out_beat) board.check(out_snap, user_snap);
        m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 26);
        if (in_beat || out_beat) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= 5000) begin
            $display("invert_3x3_matrix test failed");
            $finish;
        end
    end

    function automatic logic [9*EW-1:0] pack(elem_t e[9]);
        logic [9*EW-1:0] d;
        for (int k = 0; k < 9; k++) d[k*EW +: EW] = e[k];
        return d;
    endfunction

    function automatic elem_t near(int scale);
        return elem_t'($signed($urandom_range(2 * scale)) - scale);
    endfunction

    function automatic logic [9*EW-1:0] random_matrix();
        elem_t e[9];
        int    pick;
        pick = $urandom_range(99);
        for (int k = 0; k < 9; k++) begin
            if (pick < 25) e[k] = elem_t'($urandom);
            else if (pick < 75) e[k] = near(1 << (FRAC_BITS + $urandom_range(3)));
            else e[k] = near(1 << $urandom_range(6));
        end
        if (pick >= 60 && pick < 75) begin
            case ($urandom_range(2))
                0: for (int c = 0; c < 3; c++) e[6+c] = e[c];
                1: for (int r = 0; r < 3; r++) e[r*3+1] = '0;
                default: for (int c = 0; c < 3; c++) e[3+c] = -e[c];
            endcase
        end
        if (pick >= 75 && pick < 85) begin
            for (int k = 0; k < 9; k++) e[k] = (k % 4 == 0) ? elem_t'($urandom) : '0;
        end
        return pack(e);
    endfunction

    task automatic send(input logic [9*EW-1:0] d);
        s_tdata  <= d;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!in_beat);
        if (!calm && $urandom_range(99) < 10) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (board.pending.size() != 0) @(posedge aclk);
    endtask

    localparam elem_t ONE  = elem_t'(1 << FRAC_BITS);
    localparam elem_t MAXV = elem_t'({1'b0, {(EW-1){1'b1}}});
    localparam elem_t MINV = elem_t'({1'b1, {(EW-1){1'b0}}});

    initial begin
        elem_t e[9];
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        m_tready     = 1'b0;
        aresetn      = 1'b0;
        calm         = 1'b0;
        errors       = 0;
        quiet_cycles = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        e = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};            send(pack(e));
        e = '{0, 0, 0, 0, 0, 0, 0, 0, 0};                  send(pack(e));
        e = '{MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV}; send(pack(e));
        e = '{MINV, 0, 0, 0, MINV, 0, 0, 0, MINV};         send(pack(e));
        e = '{MAXV, 0, 0, 0, MAXV, 0, 0, 0, MAXV};         send(pack(e));
        e = '{MINV, MAXV, 0, 0, MINV, MAXV, MAXV, 0, MINV}; send(pack(e));
        e = '{1, 0, 0, 0, 1, 0, 0, 0, 1};                  send(pack(e));
        e = '{-1, 0, 0, 0, 1, 0, 0, 0, -1};                send(pack(e));
        e = '{2*ONE, ONE, 0, 3*ONE, -ONE, ONE, 0, 5*ONE, ONE}; send(pack(e));
        e = '{ONE, 2*ONE, 3*ONE, 4*ONE, 5*ONE, 6*ONE, 7*ONE, 8*ONE, 9*ONE}; send(pack(e));
        e = '{0, ONE, 0, 0, 0, ONE, ONE, 0, 0};            send(pack(e));
        e = '{-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE};         send(pack(e));
        e = '{ONE, 1, 0, 0, ONE, 0, 0, 0, 1};              send(pack(e));
        e = '{MINV, MINV, MINV, MAXV, 1, -1, 3, MINV, MAXV}; send(pack(e));
        e = '{-1, -1, -1, -1, -1, -1, -1, -1, -1};         send(pack(e));
        drain();

        for (int n = 0; n < 1050; n++) begin
            calm = (n >= 300 && n < 450);
            send(random_matrix());
            if (n == 700) drain();
        end
        drain();
        repeat (3 * (EW + 8)) @(posedge aclk);
        if (errors == 0) begin
            $display("invert_3x3_matrix test passed");
        end else begin
            $display("invert_3x3_matrix test failed");
        end
        $finish;
    end
endmodule
